// ===== sv/spsc_pkg.sv =====
// Shared types and constants for the segmented prime sieve counter.
package spsc_pkg;

    localparam int unsigned VAL_W   = 16;  // width of a range bound
    localparam int unsigned ADDR_W  = 17;  // walking address, one bit of headroom
    localparam int unsigned PRIME_W = 9;   // sieving prime, reaches 256 at the end
    localparam int unsigned COUNT_W = 13;  // prime count

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_CLEAR,
        ST_PTEST,
        ST_PCHK,
        ST_STRIKE,
        ST_SCAN,
        ST_TAIL,
        ST_DONE
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic clear_wr;
        logic ptest_rd;
        logic next_p;
        logic strike_start;
        logic strike_wr;
        logic scan_start;
        logic scan_rd;
        logic emit;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic empty;
        logic clear_last;
        logic p_done;
        logic is_prime;
        logic strike_last;
        logic scan_last;
        logic out_free;
    } stat_t;

endpackage

// ===== sv/spsc_ctrl.sv =====
// Sequencer for one query: clear, sieve, scan, deliver.
module spsc_ctrl
    import spsc_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  stat_t  stat,
    output cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) state_next = ST_START;
            end
            ST_START: begin
                state_next = stat.empty ? ST_DONE : ST_CLEAR;
            end
            ST_CLEAR: begin
                if (stat.clear_last) state_next = ST_PTEST;
            end
            ST_PTEST: begin
                state_next = stat.p_done ? ST_SCAN : ST_PCHK;
            end
            ST_PCHK: begin
                state_next = stat.is_prime ? ST_STRIKE : ST_PTEST;
            end
            ST_STRIKE: begin
                if (stat.strike_last) state_next = ST_PTEST;
            end
            ST_SCAN: begin
                if (stat.scan_last) state_next = ST_TAIL;
            end
            ST_TAIL: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (stat.out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
            end
            ST_PTEST: begin
                cmd.scan_start = stat.p_done;
                cmd.ptest_rd   = !stat.p_done;
            end
            ST_PCHK: begin
                cmd.strike_start = stat.is_prime;
                cmd.next_p       = !stat.is_prime;
            end
            ST_STRIKE: begin
                cmd.strike_wr = 1'b1;
                cmd.next_p    = stat.strike_last;
            end
            ST_SCAN: begin
                cmd.scan_rd = 1'b1;
            end
            ST_DONE: begin
                cmd.emit = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    a_emit_only_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> state_reg == ST_IDLE)
        else $error("emit did not return to idle");

    a_strike_after_check: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STRIKE && $past(state_reg) != ST_STRIKE) |->
            $past(state_reg) == ST_PCHK && $past(stat.is_prime))
        else $error("strike entered without a prime");

endmodule

// ===== sv/spsc_datapath.sv =====
// Mark bitmap, walking address, sieving prime, counter and output register.
module spsc_datapath
    import spsc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cmd_t                 cmd,
    output stat_t                stat,
    input  logic [VAL_W-1:0]     in_low,
    input  logic [VAL_W-1:0]     in_high,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [COUNT_W-1:0]   out_count
);

    localparam int unsigned DEPTH = 1 << VAL_W;

    logic                 marks [DEPTH];
    logic [VAL_W-1:0]     lo_reg, hi_reg;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [PRIME_W-1:0]   p_reg, p_next;
    logic [ADDR_W-1:0]    psq_reg, psq_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 pend_reg;
    logic                 rd_data_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]   out_count_reg;

    logic                 we;
    logic                 wdata;
    logic [VAL_W-1:0]     raddr;
    logic [ADDR_W-1:0]    strike_step;
    logic [ADDR_W-1:0]    hi_ext;

    assign hi_ext      = {1'b0, hi_reg};
    assign strike_step = addr_reg + {{(ADDR_W-PRIME_W){1'b0}}, p_reg};

    // write port: clear pass sets every mark but 0 and 1, strikes drop marks
    assign we    = cmd.clear_wr | cmd.strike_wr;
    assign wdata = cmd.clear_wr & (addr_reg >= ADDR_W'(2));
    assign raddr = cmd.ptest_rd ? {{(VAL_W-8){1'b0}}, p_reg[7:0]} : addr_reg[VAL_W-1:0];

    always_ff @(posedge aclk) begin
        if (we) marks[addr_reg[VAL_W-1:0]] <= wdata;
        rd_data_reg <= marks[raddr];
    end

    always_comb begin
        addr_next = addr_reg;
        if (cmd.load)              addr_next = '0;
        else if (cmd.clear_wr)     addr_next = addr_reg + ADDR_W'(1);
        else if (cmd.strike_start) addr_next = psq_reg;
        else if (cmd.strike_wr)    addr_next = strike_step;
        else if (cmd.scan_start)   addr_next = {1'b0, lo_reg};
        else if (cmd.scan_rd)      addr_next = addr_reg + ADDR_W'(1);
    end

    // advance the prime and keep its square: (p+1)^2 = p^2 + 2p + 1
    always_comb begin
        p_next   = p_reg;
        psq_next = psq_reg;
        if (cmd.load) begin
            p_next   = PRIME_W'(2);
            psq_next = ADDR_W'(4);
        end else if (cmd.next_p) begin
            p_next   = p_reg + PRIME_W'(1);
            psq_next = psq_reg + {{(ADDR_W-PRIME_W-1){1'b0}}, p_reg, 1'b1};
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.load)                     count_next = '0;
        else if (pend_reg && rd_data_reg) count_next = count_reg + COUNT_W'(1);
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)       out_valid_next = 1'b1;
        else if (out_ready) out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg      <= '0;
            p_reg         <= PRIME_W'(2);
            psq_reg       <= ADDR_W'(4);
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            addr_reg      <= addr_next;
            p_reg         <= p_next;
            psq_reg       <= psq_next;
            count_reg     <= count_next;
            pend_reg      <= cmd.scan_rd;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            lo_reg <= in_low;
            hi_reg <= in_high;
        end
        if (cmd.emit) out_count_reg <= count_reg;
    end

    assign stat.empty       = lo_reg > hi_reg;
    assign stat.clear_last  = addr_reg[VAL_W-1:0] == hi_reg;
    assign stat.p_done      = psq_reg > hi_ext;
    assign stat.is_prime    = rd_data_reg;
    assign stat.strike_last = strike_step > hi_ext;
    assign stat.scan_last   = addr_reg[VAL_W-1:0] == hi_reg;
    assign stat.out_free    = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_count = out_count_reg;

    a_square_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        psq_reg == ADDR_W'(p_reg * p_reg))
        else $error("prime square out of step");

    a_strike_low: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.strike_wr |-> addr_reg >= ADDR_W'(4) && addr_reg <= hi_ext)
        else $error("strike outside sieved span");

    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_rd |-> addr_reg >= {1'b0, lo_reg} && addr_reg <= hi_ext)
        else $error("scan outside query range");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before it was taken");

endmodule

// ===== sv/segmented_prime_sieve_counter.sv =====
// Top level of the segmented prime sieve counter: stream ports, controller and datapath.
//
// Each input word is a query [range_low, range_high]; the block returns one word with
// the number of primes in that closed range (0 when range_low > range_high). The work
// runs over a 65536 x 1 mark bitmap indexed by absolute value, with one write and one
// registered read port, in these steps: a clearing pass over 0..range_high, a test of
// each candidate p with p*p <= range_high (plus one closing test), a strike of every
// multiple of each prime from p*p up to range_high, and a scan of range_low..range_high.
// One query is in flight at a time; a new word is taken as soon as the sequencer is
// back in idle, even while the last result still waits in the output register.
module segmented_prime_sieve_counter
    import spsc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] range_low, [31:16] range_high
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [12:0] prime_count, [15:13] zero
);

    cmd_t               cmd;
    stat_t              stat;
    logic [COUNT_W-1:0] count;

    spsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    spsc_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_low    (s_tdata[15:0]),
        .in_high   (s_tdata[31:16]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_count (count)
    );

    // pad the count to a whole number of bytes
    assign m_tdata = {{(16-COUNT_W){1'b0}}, count};

endmodule
